FILE: rtl/core/strict_priority_band_queue_top_assert.svh
// Assertion macros for the strict-priority band queue.
// Included by the top level; relies on clk and rst being in scope there.
`ifndef STRICT_PRIORITY_BAND_QUEUE_TOP_ASSERT_SVH
`define STRICT_PRIORITY_BAND_QUEUE_TOP_ASSERT_SVH

// Check a property in the same cycle, outside reset.
`define SPBQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence after the antecedent, outside reset.
`define SPBQ_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/spbq_pkg.sv
// Types and constants shared by the strict-priority band queue.
// No dependencies.
package spbq_pkg;

  localparam int NUM_BANDS    = 3;
  localparam int HANDLE_WIDTH = 16;
  localparam int LIMIT_W      = 11;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [1:0]         DEFAULT_BAND = 2'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 11'd1024;

  // Operation codes; the unused code behaves as peek.
  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_BAND0_LIMIT = 2'd0;
  localparam logic [1:0] REG_BAND1_LIMIT = 2'd1;
  localparam logic [1:0] REG_BAND2_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_ENQ     = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_DEQ     = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_PEEK    = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [HANDLE_WIDTH-1:0] packet_handle;
    logic                    has_priority;
    logic [1:0]              priority_band;
    logic signed [31:0]      budget_us;
    logic [31:0]             stamp_us;
    logic [31:0]             now_us;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [1:0]              out_band;
  } rsp_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][LIMIT_W-1:0] limit;
  } band_limits_t;

  // Decision of the control stage, completed by the result stage.
  typedef struct packed {
    status_t    status;
    logic [1:0] band;
    logic       use_handle;
  } decision_t;

endpackage

FILE: rtl/core/spbq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module spbq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/spbq_cfg.sv
// APB-style register file holding the three band limits.
// Depends on spbq_pkg.
module spbq_cfg
  import spbq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output band_limits_t       limits
);

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        limits.limit[b] <= LIMIT_RESET;
      end
    end else if (wr) begin
      unique case (idx)
        REG_BAND0_LIMIT: limits.limit[0] <= pwdata[LIMIT_W-1:0];
        REG_BAND1_LIMIT: limits.limit[1] <= pwdata[LIMIT_W-1:0];
        REG_BAND2_LIMIT: limits.limit[2] <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BAND0_LIMIT: prdata = PDATA_W'(limits.limit[0]);
      REG_BAND1_LIMIT: prdata = PDATA_W'(limits.limit[1]);
      REG_BAND2_LIMIT: prdata = PDATA_W'(limits.limit[2]);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/spbq_ctrl.sv
// Queue control: slack check, band choice, limit check, head/tail/count update
// and packet store addressing. Depends on spbq_pkg.
module spbq_ctrl
  import spbq_pkg::*;
#(
  parameter int BAND_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   fire,
  input  req_t                                   req,
  input  band_limits_t                           limits,
  output logic                                   mem_we,
  output logic [$clog2(NUM_BANDS*BAND_DEPTH)-1:0] mem_waddr,
  output logic [HANDLE_WIDTH-1:0]                mem_wdata,
  output logic                                   mem_re,
  output logic [$clog2(NUM_BANDS*BAND_DEPTH)-1:0] mem_raddr,
  output decision_t                              dec
);

  localparam int PW = $clog2(BAND_DEPTH);
  localparam int CW = $clog2(BAND_DEPTH + 1);
  localparam int AW = $clog2(NUM_BANDS * BAND_DEPTH);
  localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [PW-1:0] head       [NUM_BANDS];
  logic [PW-1:0] head_next  [NUM_BANDS];
  logic [PW-1:0] tail       [NUM_BANDS];
  logic [PW-1:0] tail_next  [NUM_BANDS];
  logic [CW-1:0] count      [NUM_BANDS];
  logic [CW-1:0] count_next [NUM_BANDS];

  logic [31:0] slack;
  logic        timeout;
  logic [1:0]  enq_band;
  logic [CW-1:0] enq_count;
  logic        band_full;
  logic [1:0]  first_band;
  logic        any_busy;

  function automatic logic [AW-1:0] band_base(input logic [1:0] b);
    case (b)
      2'd0:    return '0;
      2'd1:    return AW'(BAND_DEPTH);
      default: return AW'(2 * BAND_DEPTH);
    endcase
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(BAND_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign slack   = $unsigned(req.budget_us) + req.stamp_us - req.now_us;
  assign timeout = slack[31];

  // Untagged and out-of-range tags fall to the default band.
  always_comb begin
    if (req.has_priority && (req.priority_band != 2'd3)) begin
      enq_band = req.priority_band;
    end else begin
      enq_band = DEFAULT_BAND;
    end
  end

  assign enq_count = count[enq_band];
  assign band_full = (MW'(enq_count) >= MW'(limits.limit[enq_band])) ||
                     (enq_count >= CW'(BAND_DEPTH));

  always_comb begin
    any_busy = 1'b1;
    if (count[0] != '0) begin
      first_band = 2'd0;
    end else if (count[1] != '0) begin
      first_band = 2'd1;
    end else if (count[2] != '0) begin
      first_band = 2'd2;
    end else begin
      first_band = 2'd0;
      any_busy   = 1'b0;
    end
  end

  assign mem_waddr = band_base(enq_band) + AW'(tail[enq_band]);
  assign mem_wdata = req.packet_handle;
  assign mem_raddr = band_base(first_band) + AW'(head[first_band]);

  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      head_next[b]  = head[b];
      tail_next[b]  = tail[b];
      count_next[b] = count[b];
    end
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    dec.status     = ST_EMPTY;
    dec.band       = 2'd0;
    dec.use_handle = 1'b0;
    if (req.func == FUNC_ENQ) begin
      if (timeout) begin
        dec.status = ST_TIMEOUT;
      end else if (band_full) begin
        dec.status = ST_LIMIT;
        dec.band   = enq_band;
      end else begin
        dec.status          = ST_ENQ;
        dec.band            = enq_band;
        mem_we              = fire;
        tail_next[enq_band]  = ptr_inc(tail[enq_band]);
        count_next[enq_band] = enq_count + CW'(1);
      end
    end else if (any_busy) begin
      dec.band       = first_band;
      dec.use_handle = 1'b1;
      mem_re         = fire;
      if (req.func == FUNC_DEQ) begin
        dec.status             = ST_DEQ;
        head_next[first_band]  = ptr_inc(head[first_band]);
        count_next[first_band] = count[first_band] - CW'(1);
      end else begin
        dec.status = ST_PEEK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        head[b]  <= '0;
        tail[b]  <= '0;
        count[b] <= '0;
      end
    end else if (fire) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

FILE: rtl/core/spbq_out.sv
// Result stage and output register: joins the decision with the store read data
// and parts the input side from a stalled output. Depends on spbq_pkg.
module spbq_out
  import spbq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  decision_t               dec,
  input  logic [HANDLE_WIDTH-1:0] rdata,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rsp_t                    out_data
);

  logic      s1_valid;
  decision_t s1_dec;
  logic      move;

  assign move     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_dec <= dec;
    end
    if (move) begin
      out_data.status     <= s1_dec.status;
      out_data.out_band   <= s1_dec.band;
      out_data.out_handle <= s1_dec.use_handle ? rdata : '0;
    end
  end

endmodule

FILE: rtl/core/strict_priority_band_queue_top.sv
// Strict-priority band queue, top level.
// Depends on spbq_pkg, spbq_cfg, spbq_ctrl, spbq_out, spbq_ram and the assert header.
//
// Three-band strict-priority queue of packet handles. Each request is an
// enqueue, a dequeue or a peek and produces exactly one result. An enqueue
// whose slack (budget + stamp - now, wrapping 32-bit, read as signed) is
// negative is dropped with a timeout status; otherwise the packet goes to its
// tagged band (tag 3 and untagged packets go to band 2) unless that band holds
// its configured limit or BAND_DEPTH packets, in which case it is dropped with
// a limit status. Dequeue and peek serve the oldest packet of the
// lowest-numbered nonempty band; peek leaves it in place. One request is taken
// every cycle while in_ready is high; its result is registered by the read of
// the packet store RAM (3 x BAND_DEPTH handles) and then by the output register.
// A result stage and an output register sit between the two sides, so one more
// request is taken while a result waits; in_ready falls only when both hold.
// The packet store needs no clearing after reset: an entry is only read once
// its band has written it. Limits are written over the APB port at byte
// addresses 0, 4 and 8 and reset to 1024; write them only while idle.
module strict_priority_band_queue_top
  import spbq_pkg::*;
#(
  parameter int BAND_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  `include "strict_priority_band_queue_top_assert.svh"

  localparam int AW = $clog2(NUM_BANDS * BAND_DEPTH);

  logic                    fire;
  band_limits_t            limits;
  decision_t               dec;
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic [HANDLE_WIDTH-1:0] mem_wdata;
  logic [HANDLE_WIDTH-1:0] mem_rdata;

  // A request is taken when valid meets ready.
  assign fire   = in_valid & in_ready;
  assign pready = 1'b1;

  spbq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .limits  (limits)
  );

  // Decide the request, advance the band pointers and drive the store ports.
  spbq_ctrl #(
    .BAND_DEPTH (BAND_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (in_data),
    .limits    (limits),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .dec       (dec)
  );

  // Packet store; read data holds until the next dequeue or peek is taken on a nonempty queue.
  spbq_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (NUM_BANDS * BAND_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Join decision and read data, hold the result until taken.
  spbq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .dec       (dec),
    .rdata     (mem_rdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The store is never written and read by the same request.
  `SPBQ_ASSERT_NOW(a_no_rw_clash, mem_we, !mem_re, "store written and read in one cycle")
  // Back-pressure on requests only arises with a result waiting at the output.
  `SPBQ_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "request stalled with output empty")
  // Every taken request has a result presented at the output after it.
  `SPBQ_ASSERT_TWO(a_result_due, fire, out_valid, "no result two cycles after request")

endmodule
